FILE: rtl/assert_macros.svh
// Assertion macros shared by the frame interval statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FIWS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FIWS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fiws_pkg.sv
// Shared types and constants of the frame interval window statistics block.
package fiws_pkg;

   localparam int unsigned TIME_WIDTH      = 64;
   localparam int unsigned US_WIDTH        = 32;
   localparam int unsigned MS_WIDTH        = 45;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP_THRESHOLD = 2'd2;

   localparam logic [TIME_WIDTH-1:0] WINDOW_LENGTH_RESET = 64'd1000000000;
   localparam logic [US_WIDTH-1:0]   GAP_THRESHOLD_RESET = 32'd33000;

   // Division by 1000 is a shift by three and a division by 125; division by
   // one million is a shift by six and a division by 15625. Each step divides
   // a value below 2^31 by multiplying with ceil(2^(31+l)/d), which is exact.
   localparam int unsigned DIV_US      = 125;
   localparam int unsigned DIV_MS      = 15625;
   localparam logic [31:0] RECIP_US    = 32'd2199023256;
   localparam logic [31:0] RECIP_MS    = 32'd2251799814;

   // Lanes of the microsecond conversion.
   localparam int unsigned LANE_GAP = 0;
   localparam int unsigned LANE_DUR = 1;

   // Item leaving the window stage, differences still in nanoseconds.
   typedef struct packed {
      logic                  has_gap;
      logic                  report;
      logic [TIME_WIDTH-1:0] gap_ns;
      logic [TIME_WIDTH-1:0] dur_ns;
      logic [TIME_WIDTH-1:0] end_ns;
   } front_item_type;

   // Item leaving the conversion pipeline, ready for the accumulators.
   typedef struct packed {
      logic                valid;
      logic                has_gap;
      logic                report;
      logic [US_WIDTH-1:0] gap_us;
      logic [US_WIDTH-1:0] dur_us;
      logic [MS_WIDTH-1:0] end_ms;
   } stat_item_type;

endpackage

FILE: rtl/fiws_div_pipe.sv
// Pipelined constant division: gap and duration to microseconds, end time to milliseconds.
module fiws_div_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     front_valid,
   input  fiws_pkg::front_item_type front,
   output fiws_pkg::stat_item_type  tail,
   output logic                     busy
);

   logic [5:0] vld_ff;
   logic [5:0] has_gap_ff;
   logic [5:0] report_ff;

   logic [1:0][63:0] us_ns;

   // Stage A: first products.
   logic [1:0]       a_big_ff;
   logic [1:0][14:0] a_us_v1_ff;
   logic [1:0][46:0] a_us_p1_ff;
   logic [1:0][23:0] a_us_lo_ff;
   logic [23:0]      a_ms_v1_ff;
   logic [55:0]      a_ms_p1_ff;
   logic [33:0]      a_ms_lo_ff;

   // Stage B: first quotients and remainders.
   logic [1:0][8:0]  b_us_q1;
   logic [1:0][14:0] b_us_rem;
   logic [10:0]      b_ms_q1;
   logic [23:0]      b_ms_rem;
   logic [1:0]       b_big_ff;
   logic [1:0][8:0]  b_us_q1_ff;
   logic [1:0][6:0]  b_us_r1_ff;
   logic [1:0][23:0] b_us_lo_ff;
   logic [10:0]      b_ms_q1_ff;
   logic [13:0]      b_ms_r1_ff;
   logic [33:0]      b_ms_lo_ff;

   // Stage C: second products.
   logic [1:0]       c_big_ff;
   logic [1:0][8:0]  c_us_q1_ff;
   logic [1:0][62:0] c_us_p2_ff;
   logic [10:0]      c_ms_q1_ff;
   logic [30:0]      c_ms_v2_ff;
   logic [62:0]      c_ms_p2_ff;
   logic [16:0]      c_ms_lo_ff;

   // Stage D: microseconds done, second millisecond remainder.
   logic [1:0][32:0] d_us_raw;
   logic [16:0]      d_ms_q2;
   logic [30:0]      d_ms_rem;
   logic [1:0][31:0] d_us_ff;
   logic [10:0]      d_ms_q1_ff;
   logic [16:0]      d_ms_q2_ff;
   logic [13:0]      d_ms_r2_ff;
   logic [16:0]      d_ms_lo_ff;

   // Stage E: third millisecond product.
   logic [1:0][31:0] e_us_ff;
   logic [10:0]      e_ms_q1_ff;
   logic [16:0]      e_ms_q2_ff;
   logic [62:0]      e_ms_p3_ff;

   // Stage F: results.
   logic [1:0][31:0]                 f_us_ff;
   logic [fiws_pkg::MS_WIDTH-1:0]    f_ms_ff;

   assign us_ns[fiws_pkg::LANE_GAP] = front.gap_ns;
   assign us_ns[fiws_pkg::LANE_DUR] = front.dur_ns;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         b_us_q1[i]  = a_us_p1_ff[i][46:38];
         b_us_rem[i] = a_us_v1_ff[i] - 15'(b_us_q1[i]) * 15'(fiws_pkg::DIV_US);
         // A value of 2^32 us or more, or any set bit from 2^42 ns up, saturates.
         d_us_raw[i] = {c_us_q1_ff[i], c_us_p2_ff[i][61:38]};
      end
      b_ms_q1  = a_ms_p1_ff[55:45];
      b_ms_rem = a_ms_v1_ff - 24'(b_ms_q1) * 24'(fiws_pkg::DIV_MS);
      d_ms_q2  = c_ms_p2_ff[61:45];
      d_ms_rem = c_ms_v2_ff - 31'(d_ms_q2) * 31'(fiws_pkg::DIV_MS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         has_gap_ff <= {has_gap_ff[4:0], front.has_gap};
         report_ff  <= {report_ff[4:0], front.report};

         for (int i = 0; i < 2; i++) begin
            a_big_ff[i]   <= |us_ns[i][63:42];
            a_us_v1_ff[i] <= us_ns[i][41:27];
            a_us_p1_ff[i] <= 47'(us_ns[i][41:27]) * 47'(fiws_pkg::RECIP_US);
            a_us_lo_ff[i] <= us_ns[i][26:3];

            b_big_ff[i]   <= a_big_ff[i];
            b_us_q1_ff[i] <= b_us_q1[i];
            b_us_r1_ff[i] <= b_us_rem[i][6:0];
            b_us_lo_ff[i] <= a_us_lo_ff[i];

            c_big_ff[i]   <= b_big_ff[i];
            c_us_q1_ff[i] <= b_us_q1_ff[i];
            c_us_p2_ff[i] <= 63'({b_us_r1_ff[i], b_us_lo_ff[i]}) * 63'(fiws_pkg::RECIP_US);

            d_us_ff[i] <= (c_big_ff[i] || d_us_raw[i][32]) ? '1 : d_us_raw[i][31:0];
            e_us_ff[i] <= d_us_ff[i];
            f_us_ff[i] <= e_us_ff[i];
         end

         a_ms_v1_ff <= front.end_ns[63:40];
         a_ms_p1_ff <= 56'(front.end_ns[63:40]) * 56'(fiws_pkg::RECIP_MS);
         a_ms_lo_ff <= front.end_ns[39:6];

         b_ms_q1_ff <= b_ms_q1;
         b_ms_r1_ff <= b_ms_rem[13:0];
         b_ms_lo_ff <= a_ms_lo_ff;

         c_ms_q1_ff <= b_ms_q1_ff;
         c_ms_v2_ff <= {b_ms_r1_ff, b_ms_lo_ff[33:17]};
         c_ms_p2_ff <= 63'({b_ms_r1_ff, b_ms_lo_ff[33:17]}) * 63'(fiws_pkg::RECIP_MS);
         c_ms_lo_ff <= b_ms_lo_ff[16:0];

         d_ms_q1_ff <= c_ms_q1_ff;
         d_ms_q2_ff <= d_ms_q2;
         d_ms_r2_ff <= d_ms_rem[13:0];
         d_ms_lo_ff <= c_ms_lo_ff;

         e_ms_q1_ff <= d_ms_q1_ff;
         e_ms_q2_ff <= d_ms_q2_ff;
         e_ms_p3_ff <= 63'({d_ms_r2_ff, d_ms_lo_ff}) * 63'(fiws_pkg::RECIP_MS);

         f_ms_ff <= {e_ms_q1_ff, e_ms_q2_ff, e_ms_p3_ff[61:45]};
      end
   end

   assign tail.valid   = vld_ff[5];
   assign tail.has_gap = has_gap_ff[5];
   assign tail.report  = report_ff[5];
   assign tail.gap_us  = f_us_ff[fiws_pkg::LANE_GAP];
   assign tail.dur_us  = f_us_ff[fiws_pkg::LANE_DUR];
   assign tail.end_ms  = f_ms_ff;
   assign busy         = |vld_ff;

endmodule

FILE: rtl/frame_interval_window_stats.sv
// Top level of the windowed present interval statistics block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  start and end time of one present, ns
//   rsp      out        rsp_valid / rsp_ready  one window report
//   csr      in         csr_valid / csr_ready  register index and write data
//
// One item is taken per cycle while the input does not stall. An item passes nine
// registers, the last of them the report register; the depth is set by the chain
// of registered constant multiplications that turn nanoseconds into microseconds
// and milliseconds.
// Reset is synchronous and returns registers and statistics to their power-on
// values at once; there is no clearing pass. Neither input port takes anything
// while reset is high. The input side stalls only when a report reaches the
// end of the pipeline while the previous one still waits to be taken. The
// register port takes writes only while no item is in flight or offered.
`include "assert_macros.svh"

module frame_interval_window_stats (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]         req_start_time_ns,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]         req_end_time_ns,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [fiws_pkg::MS_WIDTH-1:0]           rsp_end_time_ms,
   output logic [fiws_pkg::US_WIDTH-1:0]           rsp_present_count,
   output logic [fiws_pkg::US_WIDTH-1:0]           rsp_min_gap_us,
   output logic [fiws_pkg::US_WIDTH-1:0]           rsp_max_gap_us,
   output logic [fiws_pkg::US_WIDTH-1:0]           rsp_max_duration_us,
   output logic [fiws_pkg::US_WIDTH-1:0]           rsp_long_gap_count,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [fiws_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]         csr_wdata
);

   localparam int unsigned TW = fiws_pkg::TIME_WIDTH;
   localparam int unsigned UW = fiws_pkg::US_WIDTH;
   localparam int unsigned MW = fiws_pkg::MS_WIDTH;

   // Configuration registers.
   logic          enable_ff, enable_in;
   logic [TW-1:0] window_length_ff, window_length_in;
   logic [UW-1:0] gap_threshold_ff, gap_threshold_in;
   logic          csr_write;

   // Input register.
   logic          in_valid_ff;
   logic [TW-1:0] in_start_ff;
   logic [TW-1:0] in_end_ff;

   // Window and previous-present tracking.
   logic          window_open_ff;
   logic [TW-1:0] window_start_ff, window_start_in;
   logic          prev_valid_ff;
   logic [TW-1:0] prev_end_ff;
   logic [TW-1:0] window_base;
   logic [TW-1:0] elapsed;

   fiws_pkg::front_item_type front_in, front_ff;
   logic                     front_valid_ff;
   fiws_pkg::stat_item_type  tail;
   logic                     div_busy;

   // Statistics of the open window.
   logic [UW-1:0] count_ff, count_in, count_upd;
   logic [UW-1:0] min_ff, min_in, min_upd;
   logic [UW-1:0] max_ff, max_in, max_upd;
   logic [UW-1:0] dur_ff, dur_in, dur_upd;
   logic [UW-1:0] long_ff, long_in, long_upd;

   // Report register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] rsp_end_ms_ff;
   logic [UW-1:0] rsp_count_ff, rsp_min_ff, rsp_max_ff, rsp_dur_ff, rsp_long_ff;

   logic advance;
   logic tail_report;

   // The pipeline moves unless a report would overwrite one still waiting.
   assign tail_report = tail.valid && tail.report;
   assign advance     = !(tail_report && rsp_valid_ff && !rsp_ready);
   assign req_ready   = advance && !reset;

   // Registers are written only with nothing in flight and no item on offer, so a
   // write never lands on the same edge as an accepted item.
   assign csr_ready = !(reset || req_valid || in_valid_ff || front_valid_ff || div_busy ||
                        rsp_valid_ff);
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      enable_in        = enable_ff;
      window_length_in = window_length_ff;
      gap_threshold_in = gap_threshold_ff;
      case (csr_index)
         fiws_pkg::CSR_ENABLE:        enable_in        = csr_wdata[0];
         fiws_pkg::CSR_WINDOW_LENGTH: window_length_in = csr_wdata;
         fiws_pkg::CSR_GAP_THRESHOLD: gap_threshold_in = csr_wdata[UW-1:0];
         default: begin
         end
      endcase
   end

   // The first present opens the window at its own end time. The elapsed
   // time is taken modulo 2^64, so time running backwards by d closes any window of length up to 2^64 - d.
   always_comb begin
      window_base      = window_open_ff ? window_start_ff : in_end_ff;
      elapsed          = in_end_ff - window_base;
      front_in.has_gap = prev_valid_ff;
      front_in.report  = elapsed >= window_length_ff;
      front_in.gap_ns  = in_end_ff - prev_end_ff;
      front_in.dur_ns  = in_end_ff - in_start_ff;
      front_in.end_ns  = in_end_ff;
      window_start_in  = front_in.report ? in_end_ff : window_base;
   end

   fiws_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .front_valid (front_valid_ff),
      .front       (front_ff),
      .tail        (tail),
      .busy        (div_busy)
   );

   // Fold the present into the window statistics. A closing present is part
   // of its own report, after which the statistics start over.
   always_comb begin
      count_upd = count_ff + 1'b1;
      dur_upd   = (tail.dur_us > dur_ff) ? tail.dur_us : dur_ff;
      min_upd   = min_ff;
      max_upd   = max_ff;
      long_upd  = long_ff;
      if (tail.has_gap) begin
         if (tail.gap_us < min_ff) begin
            min_upd = tail.gap_us;
         end
         if (tail.gap_us > max_ff) begin
            max_upd = tail.gap_us;
         end
         if (tail.gap_us > gap_threshold_ff) begin
            long_upd = long_ff + 1'b1;
         end
      end
      if (tail.report) begin
         count_in = '0;
         min_in   = '1;
         max_in   = '0;
         dur_in   = '0;
         long_in  = '0;
      end else begin
         count_in = count_upd;
         min_in   = min_upd;
         max_in   = max_upd;
         dur_in   = dur_upd;
         long_in  = long_upd;
      end
   end

   always_comb begin
      if (advance && tail_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         window_length_ff <= fiws_pkg::WINDOW_LENGTH_RESET;
         gap_threshold_ff <= fiws_pkg::GAP_THRESHOLD_RESET;
         in_valid_ff      <= 1'b0;
         front_valid_ff   <= 1'b0;
         window_open_ff   <= 1'b0;
         window_start_ff  <= '0;
         prev_valid_ff    <= 1'b0;
         prev_end_ff      <= '0;
         count_ff         <= '0;
         min_ff           <= '1;
         max_ff           <= '0;
         dur_ff           <= '0;
         long_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            enable_ff        <= enable_in;
            window_length_ff <= window_length_in;
            gap_threshold_ff <= gap_threshold_in;
         end
         if (advance) begin
            // While disabled an item is taken and dropped without a trace.
            in_valid_ff    <= req_valid && enable_ff;
            front_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               window_open_ff  <= 1'b1;
               window_start_ff <= window_start_in;
               prev_valid_ff   <= 1'b1;
               prev_end_ff     <= in_end_ff;
            end
            if (tail.valid) begin
               count_ff <= count_in;
               min_ff   <= min_in;
               max_ff   <= max_in;
               dur_ff   <= dur_in;
               long_ff  <= long_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_start_ff <= req_start_time_ns;
         in_end_ff   <= req_end_time_ns;
         front_ff    <= front_in;
         if (tail_report) begin
            rsp_end_ms_ff <= tail.end_ms;
            rsp_count_ff  <= count_upd;
            rsp_min_ff    <= min_upd;
            rsp_max_ff    <= max_upd;
            rsp_dur_ff    <= dur_upd;
            rsp_long_ff   <= long_upd;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_end_time_ms     = rsp_end_ms_ff;
   assign rsp_present_count   = rsp_count_ff;
   assign rsp_min_gap_us      = rsp_min_ff;
   assign rsp_max_gap_us      = rsp_max_ff;
   assign rsp_max_duration_us = rsp_dur_ff;
   assign rsp_long_gap_count  = rsp_long_ff;

   // A stall only ever comes from a report meeting a full report register.
   `FIWS_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready && tail_report, "input stalled without a blocked report")
   // A new report only appears after a closing present left the pipeline.
   `FIWS_ASSERT_IMP(a_report_origin, clock, reset, $rose(rsp_valid), $past(tail_report && advance), "report appeared without a closing present")
   // Either a gap was seen, so the minimum is at most the maximum, or none was.
   `FIWS_ASSERT_IMP(a_min_max_order, clock, reset, rsp_valid, (rsp_min_gap_us <= rsp_max_gap_us) || (rsp_min_gap_us == '1 && rsp_max_gap_us == '0), "minimum gap above maximum gap")
   // A previous present implies an open window.
   `FIWS_ASSERT_IMP(a_prev_in_window, clock, reset, prev_valid_ff, window_open_ff, "previous present recorded with no open window")

endmodule

FILE: test/frame_interval_window_stats_check.sv
// Checker that predicts and compares the window reports of the frame interval statistics block.
module frame_interval_window_stats_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]      req_start_time_ns,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]      req_end_time_ns,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [fiws_pkg::MS_WIDTH-1:0]        rsp_end_time_ms,
   input  logic [fiws_pkg::US_WIDTH-1:0]        rsp_present_count,
   input  logic [fiws_pkg::US_WIDTH-1:0]        rsp_min_gap_us,
   input  logic [fiws_pkg::US_WIDTH-1:0]        rsp_max_gap_us,
   input  logic [fiws_pkg::US_WIDTH-1:0]        rsp_max_duration_us,
   input  logic [fiws_pkg::US_WIDTH-1:0]        rsp_long_gap_count,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [fiws_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fiws_pkg::TIME_WIDTH-1:0]      csr_wdata,
   output int                                   mismatches,
   output int                                   reports_due
);

   typedef struct packed {
      logic [fiws_pkg::MS_WIDTH-1:0] end_ms;
      logic [fiws_pkg::US_WIDTH-1:0] present_count;
      logic [fiws_pkg::US_WIDTH-1:0] min_gap_us;
      logic [fiws_pkg::US_WIDTH-1:0] max_gap_us;
      logic [fiws_pkg::US_WIDTH-1:0] max_duration_us;
      logic [fiws_pkg::US_WIDTH-1:0] long_gap_count;
   } window_report_type;

   // Register copies.
   logic                            collect_on;
   logic [fiws_pkg::TIME_WIDTH-1:0] window_len_ns;
   logic [fiws_pkg::US_WIDTH-1:0]   long_gap_us;

   // Window statistics as the block should hold them.
   logic                            window_open;
   logic [fiws_pkg::TIME_WIDTH-1:0] win_base_ns;
   logic                            last_end_valid;
   logic [fiws_pkg::TIME_WIDTH-1:0] last_end_ns;
   logic [fiws_pkg::US_WIDTH-1:0]   present_tally;
   logic [fiws_pkg::US_WIDTH-1:0]   min_gap;
   logic [fiws_pkg::US_WIDTH-1:0]   max_gap;
   logic [fiws_pkg::US_WIDTH-1:0]   max_dur;
   logic [fiws_pkg::US_WIDTH-1:0]   long_gaps;

   window_report_type pending_reports[$];

   function automatic logic [fiws_pkg::US_WIDTH-1:0] us_saturated(
         input logic [fiws_pkg::TIME_WIDTH-1:0] ns);
      logic [fiws_pkg::TIME_WIDTH-1:0] us;
      us = ns / 64'd1000;
      return (us > 64'h0000_0000_FFFF_FFFF) ? '1 : us[fiws_pkg::US_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [fiws_pkg::TIME_WIDTH-1:0] seen,
                                  input logic [fiws_pkg::TIME_WIDTH-1:0] wanted);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, seen, wanted);
      mismatches = mismatches + 1;
   endtask

   task automatic clear_window();
      present_tally = '0;
      min_gap       = '1;
      max_gap       = '0;
      max_dur       = '0;
      long_gaps     = '0;
   endtask

   // Folds one present into the window and queues a report when it closes the window.
   task automatic account_present(input logic [fiws_pkg::TIME_WIDTH-1:0] start_ns,
                                  input logic [fiws_pkg::TIME_WIDTH-1:0] end_ns);
      logic [fiws_pkg::US_WIDTH-1:0]   dur_us;
      logic [fiws_pkg::US_WIDTH-1:0]   gap_us;
      logic [fiws_pkg::TIME_WIDTH-1:0] end_ms_full;
      window_report_type               closing;
      if (!collect_on)
         return;
      dur_us = us_saturated(end_ns - start_ns);
      if (!window_open) begin
         window_open = 1'b1;
         win_base_ns = end_ns;
         min_gap     = '1;
      end
      if (last_end_valid) begin
         gap_us = us_saturated(end_ns - last_end_ns);
         if (gap_us < min_gap) min_gap = gap_us;
         if (gap_us > max_gap) max_gap = gap_us;
         if (gap_us > long_gap_us) long_gaps = long_gaps + 1'b1;
      end
      last_end_ns    = end_ns;
      last_end_valid = 1'b1;
      present_tally  = present_tally + 1'b1;
      if (dur_us > max_dur) max_dur = dur_us;
      if ((end_ns - win_base_ns) >= window_len_ns) begin
         end_ms_full             = end_ns / 64'd1000000;
         closing.end_ms          = end_ms_full[fiws_pkg::MS_WIDTH-1:0];
         closing.present_count   = present_tally;
         closing.min_gap_us      = min_gap;
         closing.max_gap_us      = max_gap;
         closing.max_duration_us = max_dur;
         closing.long_gap_count  = long_gaps;
         pending_reports.push_back(closing);
         win_base_ns = end_ns;
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      window_report_type seen;
      window_report_type want;
      if (reset) begin
         collect_on     = 1'b0;
         window_len_ns  = fiws_pkg::WINDOW_LENGTH_RESET;
         long_gap_us    = fiws_pkg::GAP_THRESHOLD_RESET;
         window_open    = 1'b0;
         win_base_ns    = '0;
         last_end_valid = 1'b0;
         last_end_ns    = '0;
         clear_window();
         pending_reports.delete();
         mismatches     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.end_ms          = rsp_end_time_ms;
            seen.present_count   = rsp_present_count;
            seen.min_gap_us      = rsp_min_gap_us;
            seen.max_gap_us      = rsp_max_gap_us;
            seen.max_duration_us = rsp_max_duration_us;
            seen.long_gap_count  = rsp_long_gap_count;
            if (pending_reports.size() == 0) begin
               report_mismatch("report with none expected, end_time_ms", seen.end_ms, '0);
            end else begin
               want = pending_reports.pop_front();
               if (seen.end_ms !== want.end_ms)
                  report_mismatch("end_time_ms", seen.end_ms, want.end_ms);
               if (seen.present_count !== want.present_count)
                  report_mismatch("present_count", seen.present_count, want.present_count);
               if (seen.min_gap_us !== want.min_gap_us)
                  report_mismatch("min_gap_us", seen.min_gap_us, want.min_gap_us);
               if (seen.max_gap_us !== want.max_gap_us)
                  report_mismatch("max_gap_us", seen.max_gap_us, want.max_gap_us);
               if (seen.max_duration_us !== want.max_duration_us)
                  report_mismatch("max_duration_us", seen.max_duration_us,
                                  want.max_duration_us);
               if (seen.long_gap_count !== want.long_gap_count)
                  report_mismatch("long_gap_count", seen.long_gap_count, want.long_gap_count);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fiws_pkg::CSR_ENABLE:        collect_on    = csr_wdata[0];
               fiws_pkg::CSR_WINDOW_LENGTH: window_len_ns = csr_wdata;
               fiws_pkg::CSR_GAP_THRESHOLD: long_gap_us   = csr_wdata[fiws_pkg::US_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            account_present(req_start_time_ns, req_end_time_ns);
      end
      reports_due <= pending_reports.size();
   end

endmodule

FILE: test/frame_interval_window_stats_tb.sv
// Testbench top for the frame interval window statistics block: stimulus, clock and verdict.
module frame_interval_window_stats_tb;

   // Presents that close no window leave no report to wait for, so a register write waits
   // this long past the last report to be sure that nothing is still in flight.
   localparam int PIPE_SETTLE = 16;
   // Number of collected presents after which the random part stops.
   localparam int PRESENT_TARGET = 2000;
   // Cycles that the report side holds off once while the input keeps offering presents.
   localparam int LONG_HOLD_CYCLES = 400;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [fiws_pkg::TIME_WIDTH-1:0]      req_start_time_ns = '0;
   logic [fiws_pkg::TIME_WIDTH-1:0]      req_end_time_ns = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [fiws_pkg::MS_WIDTH-1:0]        rsp_end_time_ms;
   logic [fiws_pkg::US_WIDTH-1:0]        rsp_present_count;
   logic [fiws_pkg::US_WIDTH-1:0]        rsp_min_gap_us;
   logic [fiws_pkg::US_WIDTH-1:0]        rsp_max_gap_us;
   logic [fiws_pkg::US_WIDTH-1:0]        rsp_max_duration_us;
   logic [fiws_pkg::US_WIDTH-1:0]        rsp_long_gap_count;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [fiws_pkg::CSR_INDEX_WIDTH-1:0] csr_index = fiws_pkg::CSR_ENABLE;
   logic [fiws_pkg::TIME_WIDTH-1:0]      csr_wdata = '0;

   int mismatches;
   int reports_due;

   // When set, the present side offers items back to back for the whole phase.
   bit send_burst = 1'b0;
   // Raised once by the stimulus to ask the report side for its long hold-off.
   logic hold_rsp_request = 1'b0;
   // Running time base of the well-formed present stream.
   logic [fiws_pkg::TIME_WIDTH-1:0] stream_ns = '0;

   always #5 clock = ~clock;

   frame_interval_window_stats uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_time_ns   (req_start_time_ns),
      .req_end_time_ns     (req_end_time_ns),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_end_time_ms     (rsp_end_time_ms),
      .rsp_present_count   (rsp_present_count),
      .rsp_min_gap_us      (rsp_min_gap_us),
      .rsp_max_gap_us      (rsp_max_gap_us),
      .rsp_max_duration_us (rsp_max_duration_us),
      .rsp_long_gap_count  (rsp_long_gap_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   frame_interval_window_stats_check check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_time_ns   (req_start_time_ns),
      .req_end_time_ns     (req_end_time_ns),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_end_time_ms     (rsp_end_time_ms),
      .rsp_present_count   (rsp_present_count),
      .rsp_min_gap_us      (rsp_min_gap_us),
      .rsp_max_gap_us      (rsp_max_gap_us),
      .rsp_max_duration_us (rsp_max_duration_us),
      .rsp_long_gap_count  (rsp_long_gap_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .reports_due         (reports_due)
   );

   function automatic logic [fiws_pkg::TIME_WIDTH-1:0] random_time();
      return {$urandom, $urandom};
   endfunction

   // Offers one present and returns at the edge where it is taken. Valid stays high after
   // the handshake, so a back-to-back item only changes the payload; it drops only when
   // the drawn idle time is nonzero.
   task automatic send_present(input logic [fiws_pkg::TIME_WIDTH-1:0] start_ns,
                               input logic [fiws_pkg::TIME_WIDTH-1:0] end_ns);
      int idle;
      idle = send_burst ? 0 : $urandom_range(0, 18);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_time_ns <= start_ns;
      req_end_time_ns   <= end_ns;
      do @(posedge clock); while (!req_ready);
   endtask

   // Register writes keep valid high from one write to the next; the caller lowers it.
   task automatic write_register(input logic [fiws_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [fiws_pkg::TIME_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config(input logic collect,
                               input logic [fiws_pkg::TIME_WIDTH-1:0] window_ns,
                               input logic [fiws_pkg::US_WIDTH-1:0] threshold_us);
      write_register(fiws_pkg::CSR_ENABLE, {63'd0, collect});
      write_register(fiws_pkg::CSR_WINDOW_LENGTH, window_ns);
      write_register(fiws_pkg::CSR_GAP_THRESHOLD, {32'd0, threshold_us});
      csr_valid <= 1'b0;
   endtask

   // Stops offering presents and waits until every predicted report has been taken and any
   // present that closes no window has left the pipeline. The first edge is always waited
   // out, since the count of due reports is a register that lags the last handshake.
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Builds the next present. Most follow a frame cadence with random intervals and call
   // durations; the rest are stalls that may pass the microsecond range, time stepping back,
   // jumps to just below the wrap of the 64-bit clock, and wholly random timestamps.
   task automatic make_present(output logic [fiws_pkg::TIME_WIDTH-1:0] start_ns,
                               output logic [fiws_pkg::TIME_WIDTH-1:0] end_ns);
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         stream_ns = stream_ns + 64'($urandom_range(0, 3000));
      end else if (kind < 86) begin
         stream_ns = stream_ns + 64'($urandom_range(1_000_000, 40_000_000));
      end else if (kind < 90) begin
         stream_ns = stream_ns + (random_time() >> $urandom_range(0, 24));
      end else if (kind < 94) begin
         stream_ns = stream_ns - 64'($urandom_range(0, 50_000_000));
      end else if (kind < 96) begin
         stream_ns = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 200_000_000));
      end
      if (kind >= 96) begin
         // Noise: both timestamps random, the start often after the end.
         start_ns = random_time();
         end_ns   = random_time();
         if (kind == 99)
            stream_ns = end_ns;
      end else begin
         end_ns = stream_ns;
         if ($urandom_range(0, 19) == 0)
            start_ns = end_ns + 64'($urandom_range(1, 5_000_000));
         else
            start_ns = end_ns - 64'($urandom_range(0, 20_000_000));
      end
   endtask

   // Report side: a random hold-off before each report, with stretches of none, and one
   // long hold-off on request so that the pipeline fills and the input stalls.
   initial begin
      int  hold;
      int  taken;
      bit  take_burst;
      bit  long_hold_done;
      taken          = 0;
      take_burst     = 1'b0;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_request && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         hold = take_burst ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken = taken + 1;
         if (taken % 40 == 0)
            take_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // Guard against a hang; far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [fiws_pkg::TIME_WIDTH-1:0] base_ns;
      logic [fiws_pkg::TIME_WIDTH-1:0] start_ns;
      logic [fiws_pkg::TIME_WIDTH-1:0] end_ns;
      logic [fiws_pkg::TIME_WIDTH-1:0] window_ns;
      logic [fiws_pkg::US_WIDTH-1:0]   threshold_us;
      logic                            collect;
      int                              presents_sent;
      int                              phase_items;
      int                              pick;

      presents_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset collection is off, so these presents must be dropped.
      send_present('0, '0);
      send_present('1, '1);
      drain_block();

      // Reset window length and threshold with collection on. The window opens at the first
      // present, which has no gap; a call whose end lies before its start saturates its
      // duration; the window closes exactly when its length has elapsed.
      write_register(fiws_pkg::CSR_ENABLE, 64'd1);
      csr_valid <= 1'b0;
      send_present(64'd0, 64'd0);
      send_present(64'd1000, 64'd16_666_667);
      send_present(64'd16_700_000, 64'd66_700_000);
      send_present(64'd80_000_000, 64'd70_000_000);
      send_present(64'd900_000_000, 64'd999_999_999);
      send_present(64'd990_000_000, 64'd1_000_000_000);
      // End at the top of the clock range, then wrap past zero: a gap of one nanosecond.
      send_present(64'd0, '1);
      send_present('1, 64'd0);
      // A gap of days saturates the microsecond gap.
      base_ns = 64'd5_000_000_000_000_000;
      send_present(64'd0, base_ns);
      drain_block();

      // A zero window length reports on every present; no gap can exceed the threshold.
      apply_config(1'b1, 64'd0, '1);
      send_present(base_ns, base_ns + 64'd16_000_000);
      send_present(base_ns + 64'd16_000_000, base_ns + 64'd16_000_000);
      drain_block();

      // One nanosecond window and zero threshold: a present at the same instant closes
      // nothing, one nanosecond later closes the window, and a gap of two microseconds is
      // long.
      base_ns = base_ns + 64'd16_000_000;
      apply_config(1'b1, 64'd1, '0);
      send_present(base_ns - 64'd5_000_000, base_ns);
      send_present(base_ns - 64'd5_000_000, base_ns + 64'd1);
      send_present(base_ns, base_ns + 64'd2001);
      drain_block();

      // Longest window: only a present one nanosecond before the window start, which is a
      // full turn of the clock later, closes it.
      apply_config(1'b1, '1, fiws_pkg::GAP_THRESHOLD_RESET);
      send_present(base_ns, base_ns);
      send_present(base_ns, base_ns + 64'd2000);
      drain_block();

      // Collection off in the middle of a window: the statistics must survive.
      apply_config(1'b0, fiws_pkg::WINDOW_LENGTH_RESET, fiws_pkg::GAP_THRESHOLD_RESET);
      send_present(random_time(), random_time());
      send_present(base_ns, base_ns + 64'd40_000_000);
      drain_block();

      // Every present closes a window while the report side holds off for a long time, so
      // the pipeline backs up into the input while presents keep coming.
      stream_ns = base_ns + 64'd10_000_000;
      apply_config(1'b1, 64'd0, fiws_pkg::GAP_THRESHOLD_RESET);
      hold_rsp_request <= 1'b1;
      send_burst = 1'b1;
      repeat (60) begin
         make_present(start_ns, end_ns);
         send_present(start_ns, end_ns);
      end
      drain_block();

      // Random phases, each with its own register setting and a drain before the next.
      while (presents_sent < PRESENT_TARGET) begin
         collect = ($urandom_range(0, 6) != 0);
         pick = $urandom_range(0, 11);
         if (pick == 0)
            window_ns = '0;
         else if (pick == 1)
            window_ns = 64'd1;
         else if (pick == 2)
            window_ns = '1;
         else if (pick == 3)
            window_ns = random_time();
         else
            window_ns = 64'($urandom_range(20_000_000, 300_000_000));
         pick = $urandom_range(0, 9);
         if (pick == 0)
            threshold_us = '0;
         else if (pick == 1)
            threshold_us = '1;
         else if (pick == 2)
            threshold_us = $urandom;
         else
            threshold_us = $urandom_range(5_000, 40_000);
         apply_config(collect, window_ns, threshold_us);
         send_burst = ($urandom_range(0, 3) == 0);
         phase_items = collect ? $urandom_range(30, 90) : $urandom_range(3, 10);
         repeat (phase_items) begin
            make_present(start_ns, end_ns);
            send_present(start_ns, end_ns);
            if (collect)
               presents_sent = presents_sent + 1;
         end
         drain_block();
      end

      if (mismatches == 0 && reports_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
